/* sv/update_image_packet_framer_core_defines.svh */
// Assertion macros for the update image packet framer checker.
// Depends on nothing; included by the checker file.
`ifndef UPDATE_IMAGE_PACKET_FRAMER_CORE_DEFINES_SVH
`define UPDATE_IMAGE_PACKET_FRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define IPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipf assertion failed");

// next-cycle implication
`define IPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipf assertion failed");

`endif

/* sv/ipf_pkg.sv */
// Shared types and constants of the update image packet framer.
// Depends on nothing; used by every RTL file of the block.
package ipf_pkg;

   localparam int MAX_PAYLOAD  = 61;
   localparam int LENGTH_BITS  = 24;
   localparam int RESULT_LIMIT = 48;
   localparam int JOBQ_DEPTH   = 4;

   localparam logic [23:0] LENGTH_MASK = 24'((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [7:0] SEQ_0     = 8'h01;
   localparam logic [7:0] SEQ_1     = 8'h02;
   localparam logic [7:0] SEQ_2     = 8'h03;
   localparam logic [7:0] CMD_START = 8'h01;
   localparam logic [7:0] CMD_WRITE = 8'h02;
   localparam logic [7:0] CMD_END   = 8'h03;
   localparam logic [7:0] START_LEN = 8'd12;
   localparam logic [7:0] HDR_LEN   = 8'd11;
   localparam logic [3:0] START_LAST = 4'd11;
   localparam logic [3:0] HDR_LAST   = 4'd10;

   localparam logic [15:0] TAG_END_ID = 16'hFFFF;
   localparam logic [2:0]  APP_TAG    = 3'd3;
   localparam logic [2:0]  END_TAG    = 3'd4;
   localparam logic [2:0]  TAG_LAST   = 3'd5;
   localparam logic [24:0] STREAM_OVERHEAD = 25'd30;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_SPLIT = 2'd1;
   localparam logic [1:0] REG_LEN   = 2'd2;

   localparam logic [1:0] MODE_FULL      = 2'd0;
   localparam logic [1:0] MODE_SECURE    = 2'd1;
   localparam logic [1:0] MODE_NONSECURE = 2'd2;

   localparam logic [1:0] ST_PACKET    = 2'd0;
   localparam logic [1:0] ST_TOO_SMALL = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_IDLE_BYTE = 2'd3;

   localparam logic CMD_IN_START = 1'b0;

   typedef enum logic [1:0] {
      JOB_ERR,
      JOB_START,
      JOB_BYTE
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   status;
      logic [1:0]   mode;
      logic [23:0]  sel;
      logic [7:0]   data;
      logic         last;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_STREAM,
      BK_WHDR,
      BK_END,
      BK_ERR
   } back_state_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       packet_end;
      logic       run_end;
      logic [1:0] status;
   } rsp_type;

endpackage

/* sv/ipf_front.sv */
// Front end: configuration registers, item acceptance and region classification.
// Depends on ipf_pkg; feeds jobs to ipf_jobq.
module ipf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   input  logic             accept,
   input  logic             command,
   input  logic [7:0]       image_byte,
   output logic             job_push,
   output ipf_pkg::job_type job
);

   logic [1:0]  mode_ff;
   logic [23:0] split_ff;
   logic [23:0] len_ff;
   logic        active_ff, active_in;
   logic [23:0] ipos_ff, ipos_in;
   logic [23:0] rbeg_ff, rbeg_in;
   logic [23:0] rend_ff, rend_in;
   logic [23:0] rlen_ff, rlen_in;

   logic [23:0] sel_c;
   logic [23:0] beg_c;
   logic [1:0]  st_c;
   logic [24:0] ipos_next;
   logic        in_region;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ipf_pkg::MODE_NONSECURE;
         split_ff <= '0;
         len_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ipf_pkg::REG_MODE:  mode_ff  <= csr_wdata[1:0];
            ipf_pkg::REG_SPLIT: split_ff <= csr_wdata & ipf_pkg::LENGTH_MASK;
            ipf_pkg::REG_LEN:   len_ff   <= csr_wdata & ipf_pkg::LENGTH_MASK;
            default: ;
         endcase
      end
   end

   always_comb begin
      sel_c = len_ff;
      beg_c = '0;
      st_c  = ipf_pkg::ST_PACKET;
      unique case (mode_ff)
         ipf_pkg::MODE_SECURE: begin
            sel_c = (len_ff < split_ff) ? len_ff : split_ff;
            if (sel_c == '0) st_c = ipf_pkg::ST_EMPTY;
         end
         ipf_pkg::MODE_NONSECURE: begin
            if (len_ff <= split_ff) begin
               st_c = ipf_pkg::ST_TOO_SMALL;
            end else begin
               beg_c = split_ff;
               sel_c = len_ff - split_ff;
            end
         end
         default: begin
            if (sel_c == '0) st_c = ipf_pkg::ST_EMPTY;
         end
      endcase
   end

   assign ipos_next = {1'b0, ipos_ff} + 25'd1;
   assign in_region = (ipos_ff >= rbeg_ff) && (ipos_ff < rend_ff);

   always_comb begin
      active_in = active_ff;
      ipos_in   = ipos_ff;
      rbeg_in   = rbeg_ff;
      rend_in   = rend_ff;
      rlen_in   = rlen_ff;
      job_push  = 1'b0;
      job.kind   = ipf_pkg::JOB_ERR;
      job.status = ipf_pkg::ST_PACKET;
      job.mode   = mode_ff;
      job.sel    = sel_c;
      job.data   = image_byte;
      job.last   = (ipos_next == {1'b0, rend_ff});
      if (accept) begin
         if (command == ipf_pkg::CMD_IN_START) begin
            job_push  = 1'b1;
            active_in = 1'b0;
            if (st_c != ipf_pkg::ST_PACKET) begin
               job.status = st_c;
            end else begin
               job.kind  = ipf_pkg::JOB_START;
               active_in = 1'b1;
               ipos_in   = '0;
               rbeg_in   = beg_c;
               rend_in   = beg_c + sel_c;
               rlen_in   = len_ff;
            end
         end else if (!active_ff) begin
            job_push   = 1'b1;
            job.status = ipf_pkg::ST_IDLE_BYTE;
         end else begin
            if (in_region) begin
               job_push = 1'b1;
               job.kind = ipf_pkg::JOB_BYTE;
            end
            ipos_in = ipos_next[23:0];
            if (ipos_next >= {1'b0, rlen_ff}) active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ipos_ff   <= '0;
         rbeg_ff   <= '0;
         rend_ff   <= '0;
         rlen_ff   <= '0;
      end else begin
         active_ff <= active_in;
         ipos_ff   <= ipos_in;
         rbeg_ff   <= rbeg_in;
         rend_ff   <= rend_in;
         rlen_ff   <= rlen_in;
      end
   end

endmodule

/* sv/ipf_jobq.sv */
// Short job queue between the front end and the packet sequencer.
// Depends on ipf_pkg.
module ipf_jobq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ipf_pkg::job_type wr_job,
   output logic             full,
   input  logic             pop,
   output ipf_pkg::job_type rd_job,
   output logic             empty
);

   localparam int PtrBits = $clog2(ipf_pkg::JOBQ_DEPTH);
   localparam int CntBits = $clog2(ipf_pkg::JOBQ_DEPTH + 1);

   ipf_pkg::job_type   mem_ff [ipf_pkg::JOBQ_DEPTH];
   logic [PtrBits-1:0] wptr_ff, wptr_in;
   logic [PtrBits-1:0] rptr_ff, rptr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CntBits'(ipf_pkg::JOBQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_job  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PtrBits'(ipf_pkg::JOBQ_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PtrBits'(ipf_pkg::JOBQ_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

/* sv/ipf_back.sv */
// Packet sequencer: expands jobs into START, WRITE and END packet bytes and error results.
// Depends on ipf_pkg; drains ipf_jobq and holds the result register.
module ipf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  ipf_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ipf_pkg::rsp_type rsp
);

   localparam int CntBits = $clog2(ipf_pkg::RESULT_LIMIT + 1);

   ipf_pkg::back_state_type state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [2:0]  tag_ff, tag_in;
   logic [2:0]  k_ff, k_in;
   logic        dat_ff, dat_in;
   logic        last_ff, last_in;
   logic [7:0]  data_ff, data_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  status_ff, status_in;
   logic [23:0] sel_ff, sel_in;
   logic [24:0] spos_ff, spos_in;
   logic [7:0]  cleft_ff, cleft_in;
   logic [CntBits-1:0] rcnt_ff, rcnt_in;
   ipf_pkg::rsp_type   out_ff, out_in;
   logic        ovalid_ff, ovalid_in;

   logic        go, load, emit, done, opend;
   logic [7:0]  obyte;
   logic [1:0]  ostatus;
   logic [24:0] rest;
   logic [7:0]  chunk;

   function automatic logic [7:0] pkt_byte(input logic [3:0] idx, input logic [7:0] len,
                                           input logic [7:0] cmd, input logic [24:0] ofs,
                                           input logic [7:0] cnt);
      logic [7:0] b;
      case (idx)
         4'd0:    b = len;
         4'd1:    b = ipf_pkg::SEQ_0;
         4'd2:    b = ipf_pkg::SEQ_1;
         4'd3:    b = ipf_pkg::SEQ_2;
         4'd4:    b = cmd;
         4'd5:    b = ofs[7:0];
         4'd6:    b = ofs[15:8];
         4'd7:    b = ofs[23:16];
         4'd8:    b = {7'd0, ofs[24]};
         4'd9:    b = cnt;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] tag_byte(input logic [2:0] tag, input logic [2:0] k,
                                           input logic [23:0] len);
      logic [15:0] id;
      logic [23:0] l;
      logic [7:0]  b;
      id = (tag == ipf_pkg::END_TAG) ? ipf_pkg::TAG_END_ID : {13'd0, tag};
      l  = (tag == ipf_pkg::APP_TAG) ? len : 24'd0;
      case (k)
         3'd0:    b = id[7:0];
         3'd1:    b = id[15:8];
         3'd2:    b = l[7:0];
         3'd3:    b = l[15:8];
         3'd4:    b = l[23:16];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   assign go        = !ovalid_ff || rsp_pop;
   assign rsp_empty = !ovalid_ff;
   assign rsp       = out_ff;
   assign rest      = ipf_pkg::STREAM_OVERHEAD + {1'b0, sel_ff} - spos_ff;
   assign chunk     = (rest < 25'(ipf_pkg::MAX_PAYLOAD)) ? rest[7:0]
                                                         : 8'(ipf_pkg::MAX_PAYLOAD);

   always_comb begin
      emit    = 1'b0;
      done    = 1'b0;
      opend   = 1'b0;
      obyte   = 8'd0;
      ostatus = ipf_pkg::ST_PACKET;
      unique case (state_ff)
         ipf_pkg::BK_START: begin
            emit  = 1'b1;
            obyte = pkt_byte(idx_ff, ipf_pkg::START_LEN, ipf_pkg::CMD_START, 25'd0, 8'd0);
            if (idx_ff == ipf_pkg::START_LAST) begin
               obyte = {6'd0, mode_ff};
               opend = 1'b1;
            end
         end
         ipf_pkg::BK_WHDR: begin
            emit  = 1'b1;
            obyte = pkt_byte(idx_ff, ipf_pkg::HDR_LEN + cleft_ff, ipf_pkg::CMD_WRITE,
                             spos_ff, cleft_ff);
         end
         ipf_pkg::BK_END: begin
            emit  = 1'b1;
            obyte = pkt_byte(idx_ff, ipf_pkg::HDR_LEN, ipf_pkg::CMD_END, spos_ff, 8'd0);
            opend = (idx_ff == ipf_pkg::HDR_LAST);
            done  = opend;
         end
         ipf_pkg::BK_STREAM: begin
            emit  = (cleft_ff != 8'd0);
            obyte = dat_ff ? data_ff : tag_byte(tag_ff, k_ff, sel_ff);
            opend = (cleft_ff == 8'd1);
            done  = emit && (dat_ff ? !last_ff
                                    : (k_ff == ipf_pkg::TAG_LAST && tag_ff == ipf_pkg::APP_TAG));
         end
         ipf_pkg::BK_ERR: begin
            emit    = 1'b1;
            ostatus = status_ff;
            done    = 1'b1;
         end
         default: ;
      endcase
   end

   assign load    = !job_empty && ((state_ff == ipf_pkg::BK_IDLE) || (go && done));
   assign job_pop = load;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      tag_in    = tag_ff;
      k_in      = k_ff;
      dat_in    = dat_ff;
      last_in   = last_ff;
      data_in   = data_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      sel_in    = sel_ff;
      spos_in   = spos_ff;
      cleft_in  = cleft_ff;
      rcnt_in   = rcnt_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff;
      if (go) begin
         unique case (state_ff)
            ipf_pkg::BK_START: begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == ipf_pkg::START_LAST) state_in = ipf_pkg::BK_STREAM;
            end
            ipf_pkg::BK_WHDR: begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == ipf_pkg::HDR_LAST) state_in = ipf_pkg::BK_STREAM;
            end
            ipf_pkg::BK_END: idx_in = idx_ff + 1'b1;
            ipf_pkg::BK_STREAM: begin
               if (cleft_ff == 8'd0) begin
                  cleft_in = chunk;
                  idx_in   = '0;
                  state_in = ipf_pkg::BK_WHDR;
               end else begin
                  cleft_in = cleft_ff - 1'b1;
                  spos_in  = spos_ff + 1'b1;
                  if (dat_ff) begin
                     dat_in = 1'b0;
                  end else if (k_ff == ipf_pkg::TAG_LAST) begin
                     k_in = '0;
                     if (tag_ff == ipf_pkg::END_TAG) begin
                        idx_in   = '0;
                        state_in = ipf_pkg::BK_END;
                     end else begin
                        tag_in = tag_ff + 1'b1;
                     end
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
         ovalid_in = emit && (rcnt_ff < CntBits'(ipf_pkg::RESULT_LIMIT));
         out_in.frame_byte = obyte;
         out_in.packet_end = opend;
         out_in.status     = ostatus;
         out_in.run_end    = done || (rcnt_ff == CntBits'(ipf_pkg::RESULT_LIMIT - 1));
         if (emit && rcnt_ff < CntBits'(ipf_pkg::RESULT_LIMIT)) rcnt_in = rcnt_ff + 1'b1;
         if (done) state_in = ipf_pkg::BK_IDLE;
      end
      if (load) begin
         idx_in  = '0;
         rcnt_in = '0;
         unique case (job.kind)
            ipf_pkg::JOB_START: begin
               state_in = ipf_pkg::BK_START;
               mode_in  = job.mode;
               sel_in   = job.sel;
               spos_in  = '0;
               cleft_in = '0;
               tag_in   = '0;
               k_in     = '0;
               dat_in   = 1'b0;
            end
            ipf_pkg::JOB_BYTE: begin
               state_in = ipf_pkg::BK_STREAM;
               dat_in   = 1'b1;
               data_in  = job.data;
               last_in  = job.last;
               tag_in   = ipf_pkg::END_TAG;
               k_in     = '0;
            end
            default: begin
               state_in  = ipf_pkg::BK_ERR;
               status_in = job.status;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      tag_ff    <= tag_in;
      k_ff      <= k_in;
      dat_ff    <= dat_in;
      last_ff   <= last_in;
      data_ff   <= data_in;
      mode_ff   <= mode_in;
      status_ff <= status_in;
      sel_ff    <= sel_in;
      spos_ff   <= spos_in;
      cleft_ff  <= cleft_in;
      rcnt_ff   <= rcnt_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ipf_pkg::BK_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule

/* sv/update_image_packet_framer_core.sv */
// Update image packet framer, top level.
// Depends on ipf_pkg, ipf_front, ipf_jobq and ipf_back.
//
// Input channel (req_): a queue write port. Push a start command, then the
// raw image bytes one per transfer; a transfer happens when req_push is high
// and req_full is low.
// Result channel (rsp_): a queue read port. While rsp_empty is low the oldest
// result byte is on rsp_frame_byte, rsp_packet_end, rsp_run_end and
// rsp_status; rsp_pop takes it.
// Configuration (csr_): write the mode, split and image size registers while
// the block is idle; a write lands at the edge where csr_we is high.
// An item is written into the job queue, loaded into the sequencer state and
// registered in the result register, after an idle step if it opens a WRITE
// packet. The sequencer emits one result per cycle unless the receiver
// stalls, plus an idle step per WRITE packet and between items when the job
// queue ran dry. A start command yields START, WRITE header and tag bytes,
// an in-region byte one (last also end tag, END packet), out-of-region none.
// A stalled receiver holds the result register, then the sequencer, then
// fills the four-entry job queue, after which req_full rises. Nothing drops.
// Reset empties both queues, ends any transfer and restores the registers.
module update_image_packet_framer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_image_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_packet_end,
   output logic        rsp_run_end,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   ipf_pkg::job_type wr_job, rd_job;
   ipf_pkg::rsp_type rsp;
   logic             job_push, job_full, job_pop, job_empty, accept;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   ipf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .command    (req_command),
      .image_byte (req_image_byte),
      .job_push   (job_push),
      .job        (wr_job)
   );

   ipf_jobq u_jobq (
      .clock  (clock),
      .reset  (reset),
      .push   (job_push),
      .wr_job (wr_job),
      .full   (job_full),
      .pop    (job_pop),
      .rd_job (rd_job),
      .empty  (job_empty)
   );

   ipf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (rd_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_frame_byte = rsp.frame_byte;
   assign rsp_packet_end = rsp.packet_end;
   assign rsp_run_end    = rsp.run_end;
   assign rsp_status     = rsp.status;

endmodule

/* sv/ipf_checker.sv */
// Port-level checker for the update image packet framer, bound to the top level.
// Depends on ipf_pkg and update_image_packet_framer_core_defines.svh.
`include "update_image_packet_framer_core_defines.svh"

module ipf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_packet_end,
   input logic       rsp_run_end,
   input logic [1:0] rsp_status
);

   `IPF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)
   `IPF_ASSERT_NOW(a_error_shape, clock, reset, !rsp_empty && rsp_status != ipf_pkg::ST_PACKET, rsp_frame_byte == 8'd0 && rsp_run_end && !rsp_packet_end)
   `IPF_ASSERT_NEXT(a_hold_valid, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `IPF_ASSERT_NEXT(a_hold_data, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_frame_byte) && $stable(rsp_status) && $stable(rsp_run_end))

endmodule

bind update_image_packet_framer_core ipf_checker u_ipf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_packet_end (rsp_packet_end),
   .rsp_run_end    (rsp_run_end),
   .rsp_status     (rsp_status)
);

/* bench/testbench.sv */
// Self-checking bench for update_image_packet_framer_core: queued start and
// image byte transfers, a built-in frame predictor and a result scoreboard.
// Depends on ipf_pkg and update_image_packet_framer_core.
module testbench;

   localparam logic CMD_IN_BYTE   = 1'b1;
   localparam int   TAG_BYTES     = 6;
   localparam int   PREFIX_BYTES  = 24;
   localparam int   SETTLE_CYCLES = 24;
   localparam int   HOLD_CYCLES   = 400;
   localparam int   ITEM_TARGET   = 210;

   typedef struct packed {
      logic       cmd;
      logic [7:0] payload;
   } image_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_command = 1'b0;
   logic [7:0]  req_image_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_packet_end;
   logic        rsp_run_end;
   logic [1:0]  rsp_status;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [23:0] csr_wdata = 24'd0;

   image_cmd_type    pending_items[$];
   ipf_pkg::rsp_type expected_frames[$];
   ipf_pkg::rsp_type item_frames[$];
   ipf_pkg::rsp_type want;

   int fail_count = 0;
   int accepted_items = 0;
   int rx_hold_left = 0;
   bit rx_hold_done = 1'b0;
   logic calm;

   // register shadow
   logic [1:0]  cfg_mode = ipf_pkg::MODE_NONSECURE;
   logic [23:0] cfg_split = 24'd0;
   logic [23:0] cfg_length = 24'd0;

   // transfer shadow
   logic        xfer_active = 1'b0;
   logic [24:0] img_pos = 25'd0;
   logic [24:0] strm_pos = 25'd0;
   logic [7:0]  chunk_left = 8'd0;
   logic [23:0] sel_len = 24'd0;
   logic [23:0] region_start = 24'd0;
   logic [23:0] raw_len = 24'd0;

   update_image_packet_framer_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_image_byte (req_image_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_run_end    (rsp_run_end),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   assign calm = accepted_items >= 120 && accepted_items < 170;

   function automatic void push_frame_byte(logic [7:0] value, logic pend, logic [1:0] st);
      ipf_pkg::rsp_type r;
      if (item_frames.size() < ipf_pkg::RESULT_LIMIT) begin
         r.frame_byte = value;
         r.packet_end = pend;
         r.run_end    = 1'b0;
         r.status     = st;
         item_frames.push_back(r);
      end
   endfunction

   function automatic void push_le(logic [31:0] value, int count, logic last_ends);
      for (int i = 0; i < count; i++)
         push_frame_byte(value[8*i +: 8], last_ends && i == count - 1, ipf_pkg::ST_PACKET);
   endfunction

   function automatic void push_packet_head(logic [7:0] len, logic [7:0] cmd);
      push_frame_byte(len, 1'b0, ipf_pkg::ST_PACKET);
      push_frame_byte(ipf_pkg::SEQ_0, 1'b0, ipf_pkg::ST_PACKET);
      push_frame_byte(ipf_pkg::SEQ_1, 1'b0, ipf_pkg::ST_PACKET);
      push_frame_byte(ipf_pkg::SEQ_2, 1'b0, ipf_pkg::ST_PACKET);
      push_frame_byte(cmd, 1'b0, ipf_pkg::ST_PACKET);
   endfunction

   function automatic void push_stream_byte(logic [7:0] value);
      logic [24:0] rest;
      logic [7:0]  chunk;
      if (chunk_left == 8'd0) begin
         rest = ipf_pkg::STREAM_OVERHEAD + {1'b0, sel_len} - strm_pos;
         chunk = (rest < ipf_pkg::MAX_PAYLOAD) ? rest[7:0] : 8'(ipf_pkg::MAX_PAYLOAD);
         push_packet_head(ipf_pkg::HDR_LEN + chunk, ipf_pkg::CMD_WRITE);
         push_le({7'd0, strm_pos}, 4, 1'b0);
         push_le({24'd0, chunk}, 2, 1'b0);
         chunk_left = chunk;
      end
      push_frame_byte(value, chunk_left == 8'd1, ipf_pkg::ST_PACKET);
      if (chunk_left != 8'd0) chunk_left--;
      strm_pos++;
   endfunction

   function automatic logic [7:0] tag_byte(int tag, int k, logic [23:0] len);
      logic [15:0] id;
      logic [31:0] wide;
      id = (tag == ipf_pkg::END_TAG) ? ipf_pkg::TAG_END_ID : 16'(tag);
      wide = {8'd0, len};
      if (k < 2) return id[8*k +: 8];
      return wide[8*(k-2) +: 8];
   endfunction

   function automatic void frame_item(logic cmd, logic [7:0] value);
      logic [1:0]  err;
      logic [23:0] sel;
      logic [23:0] start_at;
      logic [24:0] pos;
      logic [24:0] stop_at;
      item_frames.delete();
      if (cmd == ipf_pkg::CMD_IN_START) begin
         err = ipf_pkg::ST_PACKET;
         sel = cfg_length;
         start_at = 24'd0;
         xfer_active = 1'b0;
         if (cfg_mode == ipf_pkg::MODE_SECURE) begin
            sel = (cfg_length < cfg_split) ? cfg_length : cfg_split;
            if (sel == 24'd0) err = ipf_pkg::ST_EMPTY;
         end else if (cfg_mode == ipf_pkg::MODE_NONSECURE) begin
            if (cfg_length <= cfg_split) err = ipf_pkg::ST_TOO_SMALL;
            else begin
               start_at = cfg_split;
               sel = cfg_length - cfg_split;
            end
         end else if (sel == 24'd0) begin
            err = ipf_pkg::ST_EMPTY;
         end
         if (err != ipf_pkg::ST_PACKET) begin
            push_frame_byte(8'd0, 1'b0, err);
         end else begin
            xfer_active = 1'b1;
            img_pos = 25'd0;
            strm_pos = 25'd0;
            chunk_left = 8'd0;
            sel_len = sel;
            region_start = start_at;
            raw_len = cfg_length;
            push_packet_head(ipf_pkg::START_LEN, ipf_pkg::CMD_START);
            push_le(32'd0, 4, 1'b0);
            push_le(32'd0, 2, 1'b0);
            push_frame_byte({6'd0, cfg_mode}, 1'b1, ipf_pkg::ST_PACKET);
            for (int p = 0; p < PREFIX_BYTES; p++)
               push_stream_byte(tag_byte(p / TAG_BYTES, p % TAG_BYTES,
                                         (p / TAG_BYTES == ipf_pkg::APP_TAG) ? sel_len
                                                                             : 24'd0));
         end
      end else if (!xfer_active) begin
         push_frame_byte(8'd0, 1'b0, ipf_pkg::ST_IDLE_BYTE);
      end else begin
         pos = img_pos;
         stop_at = {1'b0, region_start} + {1'b0, sel_len};
         if (pos >= {1'b0, region_start} && pos < stop_at) begin
            push_stream_byte(value);
            if (pos + 25'd1 == stop_at) begin
               for (int k = 0; k < TAG_BYTES; k++)
                  push_stream_byte(tag_byte(ipf_pkg::END_TAG, k, 24'd0));
               push_packet_head(ipf_pkg::HDR_LEN, ipf_pkg::CMD_END);
               push_le({7'd0, strm_pos}, 4, 1'b0);
               push_le(32'd0, 2, 1'b1);
            end
         end
         img_pos = pos + 25'd1;
         if (img_pos >= {1'b0, raw_len}) xfer_active = 1'b0;
      end
      if (item_frames.size() != 0) item_frames[item_frames.size() - 1].run_end = 1'b1;
      foreach (item_frames[i]) expected_frames.push_back(item_frames[i]);
   endfunction

   function automatic void compare_field(string field, logic [7:0] exp_val, logic [7:0] got);
      if (exp_val !== got) begin
         $error("%s: expected %0h, got %0h", field, exp_val, got);
         fail_count++;
      end
   endfunction

   // scoreboard: check result transfers, predict accepted items
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_frames.size() == 0) begin
            $error("frame_byte: expected nothing, got %0h (status %0d)",
                   rsp_frame_byte, rsp_status);
            fail_count++;
         end else begin
            want = expected_frames.pop_front();
            compare_field("frame_byte", want.frame_byte, rsp_frame_byte);
            compare_field("packet_end", 8'(want.packet_end), 8'(rsp_packet_end));
            compare_field("run_end", 8'(want.run_end), 8'(rsp_run_end));
            compare_field("status", 8'(want.status), 8'(rsp_status));
         end
      end
      if (!reset && req_push && !req_full) begin
         frame_item(req_command, req_image_byte);
         void'(pending_items.pop_front());
         accepted_items++;
      end
   end

   // input driver
   always @(negedge clock) begin
      if (reset || pending_items.size() == 0 || (!calm && $urandom_range(99) < 25)) begin
         req_push <= 1'b0;
      end else begin
         req_push       <= 1'b1;
         req_command    <= pending_items[0].cmd;
         req_image_byte <= pending_items[0].payload;
      end
   end

   // long receiver hold while the sender keeps offering
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end else if (!rx_hold_done && pending_items.size() > 30) begin
         rx_hold_left <= HOLD_CYCLES;
         rx_hold_done <= 1'b1;
      end
   end

   // result receiver
   always @(negedge clock) begin
      rsp_pop <= !reset && rx_hold_left == 0 && (calm || $urandom_range(99) >= 25);
   end

   task automatic queue_item(logic cmd, logic [7:0] value);
      pending_items.push_back('{cmd: cmd, payload: value});
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ipf_pkg::REG_MODE:  cfg_mode = value[1:0];
         ipf_pkg::REG_SPLIT: cfg_split = value & ipf_pkg::LENGTH_MASK;
         ipf_pkg::REG_LEN:   cfg_length = value & ipf_pkg::LENGTH_MASK;
         default: ;
      endcase
   endtask

   task automatic program_regs(logic [1:0] mode, logic [23:0] split, logic [23:0] length);
      write_reg(ipf_pkg::REG_MODE, {22'd0, mode});
      write_reg(ipf_pkg::REG_SPLIT, split);
      write_reg(ipf_pkg::REG_LEN, length);
      @(posedge clock);
   endtask

   task automatic random_phase(bit opening);
      logic [1:0]  mode;
      logic [23:0] split;
      logic [23:0] length;
      int          shape;
      int          count;
      mode = 2'($urandom_range(2));
      split = 24'($urandom());
      case ($urandom_range(9))
         0: length = 24'($urandom_range(24'hFFFFFF, 24'hFFFF00));
         1: length = 24'($urandom_range(3));
         default: begin
            length = 24'($urandom_range(40, 1));
            split = 24'($urandom_range(int'(length) + 5));
         end
      endcase
      shape = $urandom_range(9);
      if (opening) begin
         mode = ipf_pkg::MODE_FULL;
         length = 24'd70;
         shape = 9;
      end
      program_regs(mode, split, length);
      if (shape == 0) queue_item(CMD_IN_BYTE, 8'($urandom()));
      queue_item(ipf_pkg::CMD_IN_START, 8'($urandom()));
      count = (length > 24'd120) ? $urandom_range(8, 1) : int'(length);
      if (shape == 1) count = $urandom_range(count);
      repeat (count) queue_item(CMD_IN_BYTE, 8'($urandom()));
      if (shape == 2) repeat ($urandom_range(3, 1)) queue_item(CMD_IN_BYTE, 8'($urandom()));
      if (shape == 3) begin
         queue_item(ipf_pkg::CMD_IN_START, 8'($urandom()));
         repeat ($urandom_range(6, 1)) queue_item(CMD_IN_BYTE, 8'($urandom()));
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // byte before any start, start with an image too small for the split
      queue_item(CMD_IN_BYTE, 8'hFF);
      queue_item(ipf_pkg::CMD_IN_START, 8'h00);
      drain();

      // empty selection in full and secure mode
      program_regs(ipf_pkg::MODE_FULL, 24'd0, 24'd0);
      queue_item(ipf_pkg::CMD_IN_START, 8'hFF);
      drain();
      program_regs(ipf_pkg::MODE_SECURE, 24'd0, 24'd5);
      queue_item(ipf_pkg::CMD_IN_START, 8'h00);
      drain();

      // secure part: region ends early, tail absorbed, then byte while idle
      program_regs(ipf_pkg::MODE_SECURE, 24'd3, 24'd5);
      queue_item(ipf_pkg::CMD_IN_START, 8'h00);
      queue_item(CMD_IN_BYTE, 8'hFF);
      queue_item(CMD_IN_BYTE, 8'h00);
      queue_item(CMD_IN_BYTE, 8'h5A);
      queue_item(CMD_IN_BYTE, 8'hA5);
      queue_item(CMD_IN_BYTE, 8'h3C);
      queue_item(CMD_IN_BYTE, 8'h81);
      drain();

      // nonsecure part: head absorbed
      program_regs(ipf_pkg::MODE_NONSECURE, 24'd2, 24'd4);
      queue_item(ipf_pkg::CMD_IN_START, 8'h00);
      queue_item(CMD_IN_BYTE, 8'h12);
      queue_item(CMD_IN_BYTE, 8'h34);
      queue_item(CMD_IN_BYTE, 8'hC3);
      queue_item(CMD_IN_BYTE, 8'hFE);
      drain();

      // largest image, restart while active
      program_regs(ipf_pkg::MODE_FULL, 24'd0, 24'hFFFFFF);
      queue_item(ipf_pkg::CMD_IN_START, 8'h00);
      queue_item(CMD_IN_BYTE, 8'h7F);
      queue_item(ipf_pkg::CMD_IN_START, 8'hFF);
      queue_item(CMD_IN_BYTE, 8'h80);
      drain();

      program_regs(ipf_pkg::MODE_NONSECURE, 24'hFFFFFF, 24'hFFFFFF);
      queue_item(ipf_pkg::CMD_IN_START, 8'h00);
      drain();

      random_phase(1'b1);
      while (accepted_items < ITEM_TARGET - 20) random_phase(1'b0);

      drain();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/ipf_pkg.sv
sv/ipf_front.sv
sv/ipf_jobq.sv
sv/ipf_back.sv
sv/update_image_packet_framer_core.sv
sv/ipf_checker.sv
bench/testbench.sv
